FILE: sv/cartesian_to_polar_tensor_rotation_assert.svh
// Assertion macros for the polar tensor rotation block.
// Depends on a clk and rst signal in the scope where a macro is used.
`ifndef CARTESIAN_TO_POLAR_TENSOR_ROTATION_ASSERT_SVH
`define CARTESIAN_TO_POLAR_TENSOR_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define CTP_CHECK(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ctp same-cycle check failed");
`define CTP_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ctp next-cycle check failed");
`else
`define CTP_CHECK(lbl, pre, post)
`define CTP_CHECK_NEXT(lbl, pre, post)
`endif
`endif

FILE: sv/ctp_pkg.sv
// Types and constants for the polar tensor rotation block.
// No dependencies.
package ctp_pkg;
  localparam int DW = 32;
  localparam int UW = DW - 1;
  localparam int COEF_BITS = 30;
  localparam int QW = COEF_BITS + 1;
  localparam int SQW = 2 * UW;
  localparam int R2W = SQW + 1;
  localparam int DIV_STAGES = COEF_BITS + 1;
  localparam int ROT_STAGES = 4;
  localparam int PRE_STAGES = 3;

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] strain_in_xx;
    logic signed [DW-1:0] strain_in_yy;
    logic signed [DW-1:0] strain_in_xy;
    logic signed [DW-1:0] stress_in_xx;
    logic signed [DW-1:0] stress_in_yy;
    logic signed [DW-1:0] stress_in_xy;
  } ctp_in_t;

  typedef struct packed {
    logic signed [DW-1:0] strain_out_rr;
    logic signed [DW-1:0] strain_out_tt;
    logic signed [DW-1:0] strain_out_rt;
    logic signed [DW-1:0] stress_out_rr;
    logic signed [DW-1:0] stress_out_tt;
    logic signed [DW-1:0] stress_out_rt;
    logic                 at_origin;
  } ctp_out_t;
endpackage

FILE: sv/ctp_div.sv
// Pipelined restoring divider: floor(num * 2^COEF_BITS / den), num <= den.
// Depends on ctp_pkg.
module ctp_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ctp_pkg::SQW-1:0] num,
  input  logic [ctp_pkg::R2W-1:0] den,
  output logic [ctp_pkg::QW-1:0]  quo
);
  import ctp_pkg::*;

  logic [R2W-1:0] rem [0:DIV_STAGES-1];
  logic [R2W-1:0] dp  [0:DIV_STAGES-1];
  logic [QW-1:0]  qp  [0:DIV_STAGES-1];
  logic [R2W-1:0] num_x;

  assign num_x = {1'b0, num};

  always_ff @(posedge clk) begin
    if (en) begin
      dp[0] <= den;
      if (num_x >= den) begin
        rem[0] <= num_x - den;
        qp[0]  <= QW'(1);
      end else begin
        rem[0] <= num_x;
        qp[0]  <= '0;
      end
    end
  end

  for (genvar i = 1; i < DIV_STAGES; i++) begin : g_stage
    logic [R2W:0] trial;
    assign trial = {rem[i-1], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dp[i] <= dp[i-1];
        if (trial >= {1'b0, dp[i-1]}) begin
          rem[i] <= R2W'(trial - {1'b0, dp[i-1]});
          qp[i]  <= {qp[i-1][QW-2:0], 1'b1};
        end else begin
          rem[i] <= trial[R2W-1:0];
          qp[i]  <= {qp[i-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = qp[DIV_STAGES-1];
endmodule

FILE: sv/ctp_rot.sv
// One tensor lane: rotates xx, yy, xy by the direction factors, rounds and saturates.
// Depends on ctp_pkg.
module ctp_rot (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [ctp_pkg::DW-1:0] xx,
  input  logic signed [ctp_pkg::DW-1:0] yy,
  input  logic signed [ctp_pkg::DW-1:0] xy,
  input  logic signed [ctp_pkg::DW-1:0] c2,
  input  logic signed [ctp_pkg::DW-1:0] s2,
  input  logic signed [ctp_pkg::DW-1:0] cs,
  output logic signed [ctp_pkg::DW-1:0] rr,
  output logic signed [ctp_pkg::DW-1:0] tt,
  output logic signed [ctp_pkg::DW-1:0] rt
);
  import ctp_pkg::*;

  localparam int EW = DW + 1;
  localparam int PW = 2 * EW;
  localparam int AW = PW + 2;
  localparam int HW = AW - COEF_BITS;

  logic signed [DW-1:0] xx_a, yy_a, xy_a, c2_a, s2_a;
  logic signed [EW-1:0] d_a, cs2_a, cms_a, cs_a;
  logic signed [PW-1:0] pa, pb, pc, pd, pe, pf, pg;
  logic signed [AW-1:0] rr_s, tt_s, rt_s;
  logic signed [AW-1:0] rr_h, tt_h, rt_h;

  function automatic logic signed [DW-1:0] sat(input logic signed [HW-1:0] v);
    logic signed [HW-1:0] hi;
    logic signed [HW-1:0] lo;
    hi = HW'({1'b0, {(DW-1){1'b1}}});
    lo = -hi - HW'(1);
    if (v > hi) begin
      return hi[DW-1:0];
    end else if (v < lo) begin
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  assign rr_h = rr_s + (AW'(1) <<< (COEF_BITS - 1));
  assign tt_h = tt_s + (AW'(1) <<< (COEF_BITS - 1));
  assign rt_h = rt_s + (AW'(1) <<< (COEF_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      xx_a  <= xx;
      yy_a  <= yy;
      xy_a  <= xy;
      c2_a  <= c2;
      s2_a  <= s2;
      cs_a  <= EW'(cs);
      d_a   <= EW'(yy) - EW'(xx);
      cs2_a <= {cs, 1'b0};
      cms_a <= EW'(c2) - EW'(s2);

      pa <= PW'(xx_a) * PW'(c2_a);
      pb <= PW'(yy_a) * PW'(s2_a);
      pc <= PW'(xy_a) * PW'(cs2_a);
      pd <= PW'(xx_a) * PW'(s2_a);
      pe <= PW'(yy_a) * PW'(c2_a);
      pf <= PW'(d_a) * PW'(cs_a);
      pg <= PW'(xy_a) * PW'(cms_a);

      rr_s <= AW'(pa) + AW'(pb) + AW'(pc);
      tt_s <= AW'(pd) + AW'(pe) - AW'(pc);
      rt_s <= AW'(pf) + AW'(pg);

      rr <= sat(rr_h[AW-1:COEF_BITS]);
      tt <= sat(tt_h[AW-1:COEF_BITS]);
      rt <= sat(rt_h[AW-1:COEF_BITS]);
    end
  end
endmodule

FILE: sv/cartesian_to_polar_tensor_rotation.sv
// Top level: point front end, three ratio lanes, two tensor lanes, merge and output register.
// Depends on ctp_pkg, ctp_div, ctp_rot and the assertion macro header.
//
//  channel | signals                 | direction | payload
//  point   | pt_valid, pt_stall, pt  | in        | ctp_in_t
//  polar   | pol_valid, pol_stall, pol | out     | ctp_out_t
//
// One transaction per cycle while the output register is not stalled; an accepted point passes
// through 3 front-end stages, 31 divider steps and 4 rotation stages into the output register.
// Reset clears the valid bits of every stage and the output register.
// A stalled, full output register holds the whole pipeline and stalls the point channel;
// each stalled cycle delays every result in flight.
`include "cartesian_to_polar_tensor_rotation_assert.svh"
module cartesian_to_polar_tensor_rotation (
  input  logic              clk,
  input  logic              rst,
  input  ctp_pkg::ctp_in_t  pt,
  input  logic              pt_valid,
  output logic              pt_stall,
  output ctp_pkg::ctp_out_t pol,
  output logic              pol_valid,
  input  logic              pol_stall
);
  import ctp_pkg::*;

  localparam int SIDE = PRE_STAGES + DIV_STAGES;
  localparam int LAT  = SIDE + ROT_STAGES;

  logic en;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] org;
  logic [SIDE-1:0] neg;
  logic signed [DW-1:0] tns [0:SIDE-1][0:5];

  logic [DW-1:0] ax, ay, mx;
  logic [UW-1:0] ux_c, uy_c, ux0, uy0;
  logic [SQW-1:0] sxx1, syy1, sxy1, sxx2, syy2, sxy2;
  logic [R2W-1:0] r2;
  logic [QW-1:0] c2q, s2q, csq;
  logic signed [DW-1:0] c2s, s2s, css;
  logic signed [DW-1:0] e_rr, e_tt, e_rt, t_rr, t_tt, t_rt;
  ctp_out_t merged;

  assign en       = !(pol_valid && pol_stall);
  assign pt_stall = !en;

  assign ax = pt.pos_x[DW-1] ? DW'(-pt.pos_x) : pt.pos_x;
  assign ay = pt.pos_y[DW-1] ? DW'(-pt.pos_y) : pt.pos_y;
  assign mx = (ax > ay) ? ax : ay;
  assign ux_c = mx[DW-1] ? ax[DW-1:1] : ax[UW-1:0];
  assign uy_c = mx[DW-1] ? ay[DW-1:1] : ay[UW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pt_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux0    <= ux_c;
      uy0    <= uy_c;
      org[0] <= (pt.pos_x == '0) && (pt.pos_y == '0);
      neg[0] <= pt.pos_x[DW-1] ^ pt.pos_y[DW-1];
      tns[0][0] <= pt.strain_in_xx;
      tns[0][1] <= pt.strain_in_yy;
      tns[0][2] <= pt.strain_in_xy;
      tns[0][3] <= pt.stress_in_xx;
      tns[0][4] <= pt.stress_in_yy;
      tns[0][5] <= pt.stress_in_xy;
      for (int i = 1; i < LAT; i++) begin
        org[i] <= org[i-1];
      end
      for (int i = 1; i < SIDE; i++) begin
        neg[i] <= neg[i-1];
        for (int j = 0; j < 6; j++) begin
          tns[i][j] <= tns[i-1][j];
        end
      end
      sxx1 <= SQW'(ux0) * SQW'(ux0);
      syy1 <= SQW'(uy0) * SQW'(uy0);
      sxy1 <= SQW'(ux0) * SQW'(uy0);
      sxx2 <= sxx1;
      syy2 <= syy1;
      sxy2 <= sxy1;
      r2   <= R2W'(sxx1) + R2W'(syy1);
    end
  end

  ctp_div u_div_c2 (.clk(clk), .en(en), .num(sxx2), .den(r2), .quo(c2q));
  ctp_div u_div_s2 (.clk(clk), .en(en), .num(syy2), .den(r2), .quo(s2q));
  ctp_div u_div_cs (.clk(clk), .en(en), .num(sxy2), .den(r2), .quo(csq));

  assign c2s = DW'({1'b0, c2q});
  assign s2s = DW'({1'b0, s2q});
  assign css = neg[SIDE-1] ? -DW'({1'b0, csq}) : DW'({1'b0, csq});

  ctp_rot u_rot_strain (
    .clk(clk), .en(en),
    .xx(tns[SIDE-1][0]), .yy(tns[SIDE-1][1]), .xy(tns[SIDE-1][2]),
    .c2(c2s), .s2(s2s), .cs(css),
    .rr(e_rr), .tt(e_tt), .rt(e_rt)
  );

  ctp_rot u_rot_stress (
    .clk(clk), .en(en),
    .xx(tns[SIDE-1][3]), .yy(tns[SIDE-1][4]), .xy(tns[SIDE-1][5]),
    .c2(c2s), .s2(s2s), .cs(css),
    .rr(t_rr), .tt(t_tt), .rt(t_rt)
  );

  always_comb begin
    merged = '0;
    merged.at_origin = org[LAT-1];
    if (!org[LAT-1]) begin
      merged.strain_out_rr = e_rr;
      merged.strain_out_tt = e_tt;
      merged.strain_out_rt = e_rt;
      merged.stress_out_rr = t_rr;
      merged.stress_out_tt = t_tt;
      merged.stress_out_rt = t_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pol_valid <= 1'b0;
    end else if (en) begin
      pol_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pol <= merged;
    end
  end

  `CTP_CHECK(a_stall_back, pol_valid && pol_stall, pt_stall)
  `CTP_CHECK(a_origin_zero, pol_valid && pol.at_origin, pol.stress_out_rt == '0)
  `CTP_CHECK_NEXT(a_last_to_out, en && vld[LAT-1], pol_valid)
endmodule

FILE: verif/cartesian_to_polar_tensor_rotation_tb.sv
// Testbench for cartesian_to_polar_tensor_rotation: drives mesh points with tensors,
// predicts the polar rotation in fixed point and checks every output transaction.
// Depends on ctp_pkg and the block's RTL.
`timescale 1ns / 100ps
module cartesian_to_polar_tensor_rotation_tb;
  import ctp_pkg::*;

  localparam int KB = 30;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ctp_in_t pt = '0;
  logic pt_valid = 1'b0;
  logic pt_stall;
  ctp_out_t pol;
  logic pol_valid;
  logic pol_stall = 1'b0;

  ctp_in_t pending_pts[$];
  ctp_out_t polar_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_origin = 0;
  int n_sat = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit stim_done = 1'b0;

  cartesian_to_polar_tensor_rotation u_dut (
    .clk(clk), .rst(rst), .pt(pt), .pt_valid(pt_valid), .pt_stall(pt_stall),
    .pol(pol), .pol_valid(pol_valid), .pol_stall(pol_stall)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] frac_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = 0;
    if (num >= den) begin
      q = 1;
      num -= den;
    end
    for (int i = 0; i < KB; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num -= den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [31:0] round_sat(logic signed [127:0] acc);
    logic signed [127:0] q;
    q = (acc + (128'sd1 <<< (KB - 1))) >>> KB;
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic ctp_out_t polar_of(ctp_in_t p);
    ctp_out_t o;
    logic signed [127:0] x, y, c2, s2, cs, f[6];
    logic [63:0] ax, ay, mx, ux, uy, r2;
    int sh;
    o = '0;
    x = p.pos_x;
    y = p.pos_y;
    if (x == 0 && y == 0) begin
      o.at_origin = 1'b1;
      return o;
    end
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    mx = ax > ay ? ax : ay;
    sh = 0;
    while ((mx >> sh) >= 64'h8000_0000) sh++;
    ux = ax >> sh;
    uy = ay >> sh;
    r2 = ux * ux + uy * uy;
    c2 = frac_ratio(ux * ux, r2);
    s2 = frac_ratio(uy * uy, r2);
    cs = frac_ratio(ux * uy, r2);
    if ((x < 0) != (y < 0)) cs = -cs;
    f[0] = p.strain_in_xx; f[1] = p.strain_in_yy; f[2] = p.strain_in_xy;
    f[3] = p.stress_in_xx; f[4] = p.stress_in_yy; f[5] = p.stress_in_xy;
    o.strain_out_rr = round_sat(f[0] * c2 + f[1] * s2 + f[2] * 2 * cs);
    o.strain_out_tt = round_sat(f[0] * s2 + f[1] * c2 - f[2] * 2 * cs);
    o.strain_out_rt = round_sat((f[1] - f[0]) * cs + f[2] * (c2 - s2));
    o.stress_out_rr = round_sat(f[3] * c2 + f[4] * s2 + f[5] * 2 * cs);
    o.stress_out_tt = round_sat(f[3] * s2 + f[4] * c2 - f[5] * 2 * cs);
    o.stress_out_rt = round_sat((f[4] - f[3]) * cs + f[5] * (c2 - s2));
    return o;
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 8) - 4;
      4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  task automatic add_pt(logic [31:0] x, logic [31:0] y, logic [31:0] a, logic [31:0] b,
                        logic [31:0] c, logic [31:0] d, logic [31:0] e, logic [31:0] g);
    ctp_in_t p;
    p = {x, y, a, b, c, d, e, g};
    pending_pts.push_back(p);
  endtask

  initial begin
    add_pt(0, 0, 32'h10000, 32'h20000, 32'h30000, 1, 2, 3);
    add_pt(0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    add_pt(32'h10000, 0, 32'h10000, 32'h20000, 32'h8000, 32'h10000, 32'h20000, 32'h8000);
    add_pt(0, 32'h10000, 32'h10000, 32'h20000, 32'h8000, 32'hffff0000, 5, 7);
    add_pt(32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h8000, 3, 9, 32'hfffffff0);
    add_pt(32'hffff0000, 32'h10000, 32'h10000, 32'h20000, 32'h8000, 3, 9, 1);
    add_pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
           32'h80000000, 32'h80000000, 32'h80000000);
    add_pt(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
           32'h80000000, 32'h7fffffff, 32'h80000000);
    add_pt(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
           32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_pt(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 1, 1);
    add_pt(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1);
    add_pt(1, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 32'hffffffff);
    add_pt(1, 32'hffffffff, 32'h12345678, 32'h87654321, 32'hdeadbeef, 32'h55555555,
           32'haaaaaaaa, 32'h0f0f0f0f);
    add_pt(32'h7fffffff, 1, 32'h7fffffff, 0, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000);
    add_pt(32'h30000, 32'hfffc0000, 32'h50000, 32'hfffe0000, 32'h18000, 32'h1000, 32'h2000,
           32'h3000);
    for (int i = 0; i < 550; i++)
      add_pt(pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
             pick_val(), pick_val(), pick_val());
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pt_valid && !pt_stall) begin
        polar_due.push_back(polar_of(pt));
        n_sent++;
      end
      if (!pt_valid || !pt_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pt_valid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
          pt <= pending_pts.pop_front();
          pt_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          pt_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    ctp_out_t due;
    cycles <= cycles + 1;
    if (!rst) begin
      if (pol_valid && !pol_stall) begin
        n_seen++;
        if (polar_due.size() == 0) begin
          $display("%0t: unexpected output transaction, actual %h", $time, pol);
          errors++;
        end else begin
          due = polar_due.pop_front();
          if (due.at_origin) n_origin++;
          if (due.strain_out_rr == 32'h7fffffff || due.strain_out_rr == 32'h80000000) n_sat++;
          if (pol !== due) begin
            $display("%0t: mismatch, expected %h actual %h", $time, due, pol);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pol_stall <= 1'b1;
      end else begin
        pol_stall <= 1'b0;
        recv_gap <= pick_gap();
      end
    end
  end

  initial begin
    wait (stim_done && polar_due.size() == 0 && !pt_valid);
    repeat (60) @(posedge clk);
    $display("covered %0d points (%0d at origin, %0d saturated radial strains), %0d outputs",
             n_sent, n_origin, n_sat, n_seen);
    if (errors == 0 && polar_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("end of test: mismatches");
    $finish;
  end
endmodule
